// ----- hdl/duplicate_and_mode_finder_core_macros.svh -----
// Assertion macros shared by the duplicate and mode finder RTL.
// No dependencies; defining ASSERT_OFF turns every check into nothing.
`ifndef DUPLICATE_AND_MODE_FINDER_CORE_MACROS_SVH
`define DUPLICATE_AND_MODE_FINDER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

`define DMF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define DMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DMF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)

`define DMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hdl/dmf_pkg.sv -----
// Types and constants for the duplicate and mode finder.
// No dependencies; used by dmf_cell and duplicate_and_mode_finder_core.
`default_nettype none

package dmf_pkg;

	localparam int MAX_ITEMS_DEF = 128;
	localparam int VALUE_W = 32;
	localparam int DUP_W = 7;
	localparam int MODE_W = 8;
	localparam int DUP_MAX = 127;
	localparam int MODE_MAX = 255;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic last;
	} in_item_t;

	typedef struct packed {
		logic [DUP_W-1:0] duplicate_count;
		logic signed [VALUE_W-1:0] mode_value;
		logic [MODE_W-1:0] mode_count;
		logic overflow;
	} out_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] s;
		logic [VALUE_W-1:0] m;
		logic sv;
		logic mv;
	} cell_link_t;

	typedef struct packed {
		logic load;
		logic cmp;
		logic red;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/duplicate_and_mode_finder_core.sv -----
// Top level of the duplicate and mode finder: chain of dmf_cell instances,
// sequencer and tally. Depends on dmf_pkg, dmf_cell and the macros header.
//
// Elements are taken one per cycle while busy is low and are shifted into a
// chain of MAX_ITEMS cells; elements beyond capacity are dropped and flagged.
// After the transfer marked last, busy stays high while a copy of the set
// slides along the chain and every cell counts later equal elements, and then
// while the chain shifts out into the tally. The result is then shown for
// exactly one cycle with done high, and it cannot be held off, so it must be
// taken when it appears. A new set may start in that same cycle.
`default_nettype none
`include "duplicate_and_mode_finder_core_macros.svh"

module duplicate_and_mode_finder_core
	import dmf_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire in_item_t item,
	output logic          done,
	output out_item_t     result
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int EW = CW + 8;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_RED  = 2'd2;

	logic [1:0]         state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      ctr_q;
	logic               ovf_q;
	logic               done_q;
	out_item_t          result_q;
	logic [CW-1:0]      dup_q;
	logic [CW-1:0]      bcnt_q;
	logic [VALUE_W-1:0] bval_q;

	logic               accept;
	logic               store;
	logic [CW-1:0]      n_next;
	cell_ctl_t          ctl;
	cell_link_t         head;
	cell_link_t         tail;
	cell_link_t         lnk [MAX_ITEMS];
	logic [CW-1:0]      cnt_w [MAX_ITEMS];
	logic [CW-1:0]      head_cnt;
	logic [CW-1:0]      dup_nx;
	logic [CW-1:0]      bcnt_nx;
	logic [VALUE_W-1:0] bval_nx;
	logic [EW-1:0]      dup_ext;
	logic [EW-1:0]      bcnt_ext;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign store  = accept && (count_q != CW'(MAX_ITEMS));
	assign n_next = store ? count_q + 1'b1 : count_q;

	assign ctl.load = store;
	assign ctl.cmp  = (state_q == ST_CMP);
	assign ctl.red  = (state_q == ST_RED);

	assign head = '{s: item.value, m: item.value, sv: 1'b1, mv: ctl.load};
	assign tail = '{s: '0, m: '0, sv: 1'b0, mv: 1'b0};

	for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
		cell_link_t    prev_l;
		cell_link_t    next_l;
		logic [CW-1:0] next_c;

		if (k == 0) begin : g_first
			assign prev_l = head;
		end else begin : g_inner
			assign prev_l = lnk[k-1];
		end

		if (k == MAX_ITEMS - 1) begin : g_last
			assign next_l = tail;
			assign next_c = '0;
		end else begin : g_mid
			assign next_l = lnk[k+1];
			assign next_c = cnt_w[k+1];
		end

		dmf_cell #(
			.CW(CW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.prev     (prev_l),
			.next     (next_l),
			.next_cnt (next_c),
			.cur      (lnk[k]),
			.cnt      (cnt_w[k])
		);
	end

	// Cells leave the chain from the latest element to the earliest, so a tie
	// goes to the one seen first.
	always_comb begin
		head_cnt = cnt_w[0] + 1'b1;
		dup_nx   = (cnt_w[0] != '0) ? dup_q + 1'b1 : dup_q;
		bcnt_nx  = bcnt_q;
		bval_nx  = bval_q;
		if (head_cnt >= bcnt_q) begin
			bcnt_nx = head_cnt;
			bval_nx = lnk[0].s;
		end
		dup_ext  = EW'(dup_nx);
		bcnt_ext = EW'(bcnt_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ctr_q   <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= n_next;
						if (!store) begin
							ovf_q <= 1'b1;
						end
						if (item.last) begin
							state_q <= ST_CMP;
							ctr_q   <= n_next;
						end
					end
				end
				ST_CMP: begin
					if (ctr_q == CW'(1)) begin
						state_q <= ST_RED;
						ctr_q   <= count_q;
					end else begin
						ctr_q <= ctr_q - 1'b1;
					end
				end
				ST_RED: begin
					if (ctr_q == CW'(1)) begin
						state_q <= ST_IDLE;
						count_q <= '0;
						ovf_q   <= 1'b0;
						done_q  <= 1'b1;
					end else begin
						ctr_q <= ctr_q - 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CMP && ctr_q == CW'(1)) begin
			dup_q  <= '0;
			bcnt_q <= '0;
			bval_q <= '0;
		end else if (state_q == ST_RED) begin
			dup_q  <= dup_nx;
			bcnt_q <= bcnt_nx;
			bval_q <= bval_nx;
		end
		if (state_q == ST_RED && ctr_q == CW'(1)) begin
			result_q.duplicate_count <= (dup_ext > EW'(DUP_MAX)) ?
				DUP_W'(DUP_MAX) : dup_ext[DUP_W-1:0];
			result_q.mode_value      <= bval_nx;
			result_q.mode_count      <= (bcnt_ext > EW'(MODE_MAX)) ?
				MODE_W'(MODE_MAX) : bcnt_ext[MODE_W-1:0];
			result_q.overflow        <= ovf_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`DMF_ASSERT_NEXT(a_done_after_tally, clk, arst_n, (state_q == ST_RED) && (ctr_q == CW'(1)), done_q, "result strobe missing after tally")
	`DMF_ASSERT_NEXT(a_last_starts_work, clk, arst_n, accept && item.last, busy, "closing transfer did not start the comparison")
	`DMF_ASSERT_ALWAYS(a_count_in_range, clk, arst_n, count_q <= CW'(MAX_ITEMS), "element count beyond capacity")
	`DMF_ASSERT_ALWAYS(a_done_only_idle, clk, arst_n, !done_q || (state_q == ST_IDLE), "result strobe while busy")

endmodule

`default_nettype wire

// ----- hdl/dmf_cell.sv -----
// One cell of the element chain: holds a stored element, a moving probe copy
// and the count of later matches. Depends on dmf_pkg.
`default_nettype none

module dmf_cell
	import dmf_pkg::*;
#(
	parameter int CW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cell_ctl_t     ctl,
	input  wire cell_link_t    prev,
	input  wire cell_link_t    next,
	input  wire logic [CW-1:0] next_cnt,
	output cell_link_t         cur,
	output logic [CW-1:0]      cnt
);

	logic [VALUE_W-1:0] s_q;
	logic [VALUE_W-1:0] m_q;
	logic               sv_q;
	logic               mv_q;
	logic [CW-1:0]      cnt_q;
	logic               hit;

	assign hit = sv_q && prev.mv && (s_q == prev.m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_q <= 1'b0;
			mv_q <= 1'b0;
		end else if (ctl.load) begin
			sv_q <= prev.sv;
			mv_q <= prev.mv;
		end else if (ctl.cmp) begin
			mv_q <= prev.mv;
		end else if (ctl.red) begin
			sv_q <= next.sv;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			s_q   <= prev.s;
			m_q   <= prev.m;
			cnt_q <= '0;
		end else if (ctl.cmp) begin
			m_q <= prev.m;
			if (hit) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end else if (ctl.red) begin
			s_q   <= next.s;
			cnt_q <= next_cnt;
		end
	end

	assign cur = '{s: s_q, m: m_q, sv: sv_q, mv: mv_q};
	assign cnt = cnt_q;

endmodule

`default_nettype wire
